FILE: sv/ctw_pkg.sv
// Shared types and constants for the card information tuple walker.
package ctw_pkg;

  localparam logic [7:0] CODE_END    = 8'hFF;
  localparam logic [7:0] CODE_FUNCID = 8'h21;
  localparam logic [7:0] CODE_CONFIG = 8'h1A;

  localparam logic [7:0] EXPECTED_FUNCTION_RESET = 8'd4;
  localparam logic [7:0] CONFIG_OPTION_RESET     = 8'd1;

  localparam logic [7:0] IDX_FUNC_CLASS = 8'd0;
  localparam logic [7:0] IDX_BASE_LOW   = 8'd2;
  localparam logic [7:0] IDX_BASE_HIGH  = 8'd3;

  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_LINK = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CLASS   = 2'd1,
    ST_NO_BASE = 2'd2
  } walk_status_t;

  typedef enum logic [0:0] {
    REG_EXPECTED_FUNCTION = 1'b0,
    REG_CONFIG_OPTION     = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] info_byte;
    logic       start_walk;
  } byte_req_t;

  typedef struct packed {
    logic [1:0]  walk_status;
    logic [15:0] option_reg_address;
    logic [7:0]  option_write_data;
    logic [7:0]  function_seen;
  } walk_res_t;

endpackage

FILE: sv/ctw_if.sv
// Valid/ready channel interfaces for structure bytes and walk results.
interface ctw_byte_if;
  logic                valid;
  logic                ready;
  ctw_pkg::byte_req_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ctw_result_if;
  logic                valid;
  logic                ready;
  ctw_pkg::walk_res_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/card_info_tuple_walker.sv
// Card information tuple walker: parses tuple bytes and reports the config register base.
// One structure byte is taken per cycle on byte_chan with no gaps of its own; a byte
// is held in the input register and, if it is the end code, its result is then
// registered in the result register and shown on result_chan. The only stall comes
// from the result register: while it holds an untaken result and the staged byte is
// an end code, byte_chan.ready drops. No clearing pass is needed after reset.
module card_info_tuple_walker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  ctw_pkg::cfg_index_t   wr_index,
  input  logic [7:0]            wr_data,
  ctw_byte_if.sink              byte_chan,
  ctw_result_if.source          result_chan
);
  import ctw_pkg::*;

  logic [7:0]  expected_function;
  logic [7:0]  config_option_value;

  logic        stg_vld;
  logic [7:0]  stg_byte;
  logic        stg_start;

  phase_t      phase, phase_next;
  logic [7:0]  tuple_code, tuple_code_next;
  logic [7:0]  body_length, body_length_next;
  logic [7:0]  body_index, body_index_next;
  logic [7:0]  function_capture, function_capture_next;
  logic [7:0]  base_low_capture, base_low_capture_next;
  logic [15:0] base_capture, base_capture_next;

  logic        res_vld;
  walk_res_t   res, res_next;
  logic        res_fire;

  logic        advance;
  logic        stg_take;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_function   <= EXPECTED_FUNCTION_RESET;
      config_option_value <= CONFIG_OPTION_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_EXPECTED_FUNCTION: expected_function   <= wr_data;
        REG_CONFIG_OPTION:     config_option_value <= wr_data;
        default:               ;
      endcase
    end
  end

  // parse step for the staged byte
  always_comb begin
    logic [7:0] func_eff;
    logic [7:0] low_eff;
    logic [15:0] base_eff;
    phase_t ph_eff;
    logic [7:0] idx_inc;

    func_eff = stg_start ? 8'd0 : function_capture;
    low_eff  = stg_start ? 8'd0 : base_low_capture;
    base_eff = stg_start ? 16'd0 : base_capture;
    ph_eff   = stg_start ? PH_CODE : phase;
    idx_inc  = body_index + 8'd1;

    phase_next            = ph_eff;
    tuple_code_next       = tuple_code;
    body_length_next      = body_length;
    body_index_next       = body_index;
    function_capture_next = func_eff;
    base_low_capture_next = low_eff;
    base_capture_next     = base_eff;
    res_fire              = 1'b0;

    unique case (ph_eff)
      PH_LINK: begin
        body_length_next = stg_byte;
        body_index_next  = 8'd0;
        phase_next       = (stg_byte == 8'd0) ? PH_CODE : PH_BODY;
      end
      PH_BODY: begin
        if (tuple_code == CODE_FUNCID && body_index == IDX_FUNC_CLASS) begin
          function_capture_next = stg_byte;
        end else if (tuple_code == CODE_CONFIG) begin
          if (body_index == IDX_BASE_LOW) begin
            base_low_capture_next = stg_byte;
          end else if (body_index == IDX_BASE_HIGH) begin
            base_capture_next = {stg_byte, low_eff};
          end
        end
        body_index_next = idx_inc;
        if (idx_inc == body_length) begin
          phase_next = PH_CODE;
        end
      end
      default: begin
        tuple_code_next = stg_byte;
        if (stg_byte != CODE_END) begin
          phase_next = PH_LINK;
        end else begin
          phase_next = PH_CODE;
          res_fire   = 1'b1;
        end
      end
    endcase

    if (func_eff != expected_function) begin
      res_next.walk_status = ST_CLASS;
    end else if (base_eff == 16'd0) begin
      res_next.walk_status = ST_NO_BASE;
    end else begin
      res_next.walk_status = ST_OK;
    end
    res_next.option_reg_address = base_eff;
    res_next.option_write_data  = (res_next.walk_status == ST_OK) ? config_option_value : 8'd0;
    res_next.function_seen      = func_eff;
  end

  assign advance  = stg_vld && (!res_fire || !res_vld || result_chan.ready);
  assign stg_take = !stg_vld || advance;

  assign byte_chan.ready     = stg_take;
  assign result_chan.valid   = res_vld;
  assign result_chan.payload = res;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld <= 1'b0;
    end else if (stg_take) begin
      stg_vld <= byte_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_take && byte_chan.valid) begin
      stg_byte  <= byte_chan.payload.info_byte;
      stg_start <= byte_chan.payload.start_walk;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_CODE;
      tuple_code       <= 8'd0;
      body_length      <= 8'd0;
      body_index       <= 8'd0;
      function_capture <= 8'd0;
      base_low_capture <= 8'd0;
      base_capture     <= 16'd0;
    end else if (advance) begin
      phase            <= phase_next;
      tuple_code       <= tuple_code_next;
      body_length      <= body_length_next;
      body_index       <= body_index_next;
      function_capture <= function_capture_next;
      base_low_capture <= base_low_capture_next;
      base_capture     <= base_capture_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (advance && res_fire) begin
      res_vld <= 1'b1;
    end else if (result_chan.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_fire) begin
      res <= res_next;
    end
  end

  a_ok_consistent: assert property (@(posedge clk) disable iff (rst)
    res_vld && res.walk_status == ST_OK |->
      res.function_seen == expected_function && res.option_reg_address != 16'd0)
    else $error("ok status with mismatched class or zero base");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    res_vld && res.walk_status != ST_OK |-> res.option_write_data == 8'd0)
    else $error("write data given on failed walk");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !byte_chan.ready |-> stg_vld && res_vld && res_fire)
    else $error("input stalled without a blocked result");

  a_start_code: assert property (@(posedge clk) disable iff (rst)
    advance && stg_start && stg_byte != CODE_END |=> phase == PH_LINK)
    else $error("start byte not taken as tuple code");

  a_end_result: assert property (@(posedge clk) disable iff (rst)
    advance && res_fire |=> res_vld && phase == PH_CODE)
    else $error("end code did not give a result");

endmodule

FILE: tb/tb_top.sv
// Testbench for the card information tuple walker: queued byte driver, clocked monitor, checker.
`timescale 1ns / 100ps

module tb_top;
  import ctw_pkg::*;

  localparam int IDLE_PCT     = 26;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;

  logic       clk;
  logic       rst;
  logic       wr_en;
  cfg_index_t wr_index;
  logic [7:0] wr_data;

  ctw_byte_if   byte_chan ();
  ctw_result_if result_chan ();

  card_info_tuple_walker u_top (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .byte_chan   (byte_chan),
    .result_chan (result_chan)
  );

  // predictor state and register copies
  phase_t     walk_phase;
  logic [7:0] cur_code;
  logic [7:0] cur_len;
  logic [7:0] cur_idx;
  logic [7:0] class_seen;
  logic [7:0] low_byte;
  logic [15:0] base_addr;
  logic [7:0] want_class;
  logic [7:0] option_value;

  byte_req_t  pending_bytes[$];
  walk_res_t  expected_results[$];
  walk_res_t  got_res;
  walk_res_t  want_res;

  int  sent_total;
  int  taken_total;
  int  mismatches;
  int  cycle_count;
  int  hold_req;
  int  hold_left;
  bit  no_idle;
  bit  byte_taken;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  task automatic walk_byte(input byte_req_t req);
    walk_res_t    res;
    walk_status_t st;
    if (req.start_walk) begin
      class_seen = '0;
      low_byte   = '0;
      base_addr  = '0;
      walk_phase = PH_CODE;
    end
    case (walk_phase)
      PH_LINK: begin
        cur_len    = req.info_byte;
        cur_idx    = '0;
        walk_phase = (req.info_byte == 8'd0) ? PH_CODE : PH_BODY;
      end
      PH_BODY: begin
        if (cur_code == CODE_FUNCID && cur_idx == IDX_FUNC_CLASS) begin
          class_seen = req.info_byte;
        end else if (cur_code == CODE_CONFIG) begin
          if (cur_idx == IDX_BASE_LOW) low_byte = req.info_byte;
          else if (cur_idx == IDX_BASE_HIGH) base_addr = {req.info_byte, low_byte};
        end
        cur_idx = cur_idx + 8'd1;
        if (cur_idx == cur_len) walk_phase = PH_CODE;
      end
      default: begin
        cur_code = req.info_byte;
        walk_phase = (req.info_byte == CODE_END) ? PH_CODE : PH_LINK;
        if (req.info_byte == CODE_END) begin
          if (class_seen != want_class) st = ST_CLASS;
          else if (base_addr == 16'd0) st = ST_NO_BASE;
          else st = ST_OK;
          res.walk_status        = st;
          res.option_reg_address = base_addr;
          res.option_write_data  = (st == ST_OK) ? option_value : 8'd0;
          res.function_seen      = class_seen;
          expected_results.push_back(res);
        end
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic s);
    byte_req_t req;
    req.info_byte  = b;
    req.start_walk = s;
    pending_bytes.push_back(req);
    sent_total++;
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    if (idx == REG_EXPECTED_FUNCTION) want_class = val;
    else option_value = val;
  endtask

  task automatic wait_idle();
    while (taken_total != sent_total || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one well-formed walk with random content, ending in the end code
  task automatic push_walk();
    int         ntup;
    int         kind;
    int         len;
    logic [7:0] code;
    logic [7:0] b;
    logic       first;
    ntup  = $urandom_range(0, 4);
    first = ($urandom_range(0, 4) != 0);
    for (int i = 0; i < ntup; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        code = CODE_FUNCID;
        len  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      end else if (kind < 6) begin
        code = CODE_CONFIG;
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 6);
      end else begin
        code = 8'($urandom_range(0, 254));
        len  = ($urandom_range(0, 29) == 0) ? 255 : $urandom_range(0, 5);
      end
      push_byte(code, first);
      first = 1'b0;
      push_byte(len[7:0], 1'b0);
      for (int j = 0; j < len; j++) begin
        b = 8'($urandom_range(0, 255));
        if (code == CODE_FUNCID && j == 0 && $urandom_range(0, 9) < 7) b = want_class;
        if (code == CODE_CONFIG && (j == 2 || j == 3) && $urandom_range(0, 6) == 0) b = 8'd0;
        push_byte(b, 1'b0);
      end
    end
    push_byte(CODE_END, first);
  endtask

  task automatic push_random(input int target);
    int         base_count;
    int         n;
    logic [7:0] b;
    base_count = sent_total;
    while (sent_total - base_count < target) begin
      if ($urandom_range(0, 99) < 85) begin
        push_walk();
      end else begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
          b = ($urandom_range(0, 9) == 0) ? CODE_END : 8'($urandom_range(0, 255));
          push_byte(b, $urandom_range(0, 9) == 0);
        end
      end
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      byte_chan.valid <= 1'b0;
    end else if (byte_taken || !byte_chan.valid) begin
      if (pending_bytes.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
        byte_chan.valid   <= 1'b1;
        byte_chan.payload <= pending_bytes.pop_front();
      end else begin
        byte_chan.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      result_chan.ready <= 1'b0;
    end else if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
      result_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      result_chan.ready <= 1'b0;
    end else begin
      result_chan.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      byte_taken = !rst && byte_chan.valid && byte_chan.ready;
      if (byte_taken) begin
        walk_byte(byte_chan.payload);
        taken_total++;
      end
      if (!rst && result_chan.valid && result_chan.ready) begin
        got_res = result_chan.payload;
        if (expected_results.size() == 0) begin
          report_mismatch("result with none pending", got_res.walk_status, 0);
        end else begin
          want_res = expected_results.pop_front();
          if (got_res.walk_status != want_res.walk_status)
            report_mismatch("walk_status", got_res.walk_status, want_res.walk_status);
          if (got_res.option_reg_address != want_res.option_reg_address)
            report_mismatch("option_reg_address", got_res.option_reg_address,
                            want_res.option_reg_address);
          if (got_res.option_write_data != want_res.option_write_data)
            report_mismatch("option_write_data", got_res.option_write_data,
                            want_res.option_write_data);
          if (got_res.function_seen != want_res.function_seen)
            report_mismatch("function_seen", got_res.function_seen, want_res.function_seen);
        end
      end
    end
  end

  initial begin
    rst               = 1'b1;
    wr_en             = 1'b0;
    wr_index          = REG_EXPECTED_FUNCTION;
    wr_data           = '0;
    byte_chan.valid   = 1'b0;
    byte_chan.payload = '0;
    result_chan.ready = 1'b0;
    walk_phase        = PH_CODE;
    cur_code          = '0;
    cur_len           = '0;
    cur_idx           = '0;
    class_seen        = '0;
    low_byte          = '0;
    base_addr         = '0;
    want_class        = EXPECTED_FUNCTION_RESET;
    option_value      = CONFIG_OPTION_RESET;
    sent_total        = 0;
    taken_total       = 0;
    mismatches        = 0;
    cycle_count       = 0;
    hold_req          = 0;
    hold_left         = 0;
    no_idle           = 1'b0;
    byte_taken        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset register values
    push_byte(CODE_FUNCID, 1'b1);
    push_byte(8'h02, 1'b0);
    push_byte(8'h04, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(CODE_CONFIG, 1'b0);
    push_byte(8'h04, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(CODE_END, 1'b0);
    // short config tuple after the end: low byte only, base kept
    push_byte(CODE_CONFIG, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h77, 1'b0);
    push_byte(CODE_END, 1'b0);
    // zero link, no base
    push_byte(CODE_FUNCID, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h04, 1'b0);
    push_byte(8'h10, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(CODE_END, 1'b0);
    // new walk abandons a tuple in progress; class then mismatches
    push_byte(CODE_CONFIG, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(CODE_END, 1'b1);
    wait_idle();

    // low extreme / high option, no idling
    write_reg(REG_EXPECTED_FUNCTION, 8'h00);
    write_reg(REG_CONFIG_OPTION, 8'hFF);
    @(posedge clk);
    no_idle = 1'b1;
    push_random(150);
    wait_idle();
    no_idle = 1'b0;

    // high extreme; result side held off while end codes keep coming
    write_reg(REG_EXPECTED_FUNCTION, 8'hFF);
    write_reg(REG_CONFIG_OPTION, 8'h00);
    @(posedge clk);
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) push_byte(CODE_END, i == 0);
    push_random(110);
    wait_idle();

    for (int k = 0; k < 3; k++) begin
      write_reg(REG_EXPECTED_FUNCTION, 8'($urandom_range(0, 255)));
      write_reg(REG_CONFIG_OPTION, 8'($urandom_range(0, 255)));
      @(posedge clk);
      push_random(110);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
